// ----- hdl/bfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and codes for the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 32;

    localparam logic [31:0] REGION_SIZE_RST = 32'd65536;
    localparam logic [31:0] MIN_SLACK_RST   = 32'd16;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_TAB_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FND  = 2'd3;

    localparam logic REG_REGION_SIZE = 1'b0;
    localparam logic REG_MIN_SLACK   = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] request_size;
        logic [31:0] target_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_address;
    } t_rsp;

endpackage

// ----- hdl/bfsa_seg_ram.sv -----
// ----------------------------------------------------------------------------
// bfsa_seg_ram
// Segment table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfsa_seg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ----- hdl/best_fit_segment_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_unit
// Best-fit segment allocator over an address-ordered segment table held in
// one synchronous RAM, with free-run coalescing and tail-end splitting.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_ready      i_in_req  (t_req)
//  response  out        o_out_valid / i_out_ready    o_out_rsp (t_rsp)
//  config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  One request at a time. A scan reads the table entry by entry (each read
//  waits on the registered RAM output), a coalescing pass walks the entries
//  from where it starts, a split shifts each later entry up one slot, and a
//  reinitialise does no scan; an allocate may coalesce, rescan and split.
//  After reset the S_INIT state initialises entry 0 before the first request.
//  A pending response holds the next result back; the next request is taken
//  as soon as the previous one has been handed to the output register.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bfsa_pkg::t_req  i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bfsa_pkg::t_rsp  o_out_rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import bfsa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int XW = (AW > 32) ? AW : 32;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 2 * AW + 1;

    typedef enum logic [11:0] {
        S_INIT   = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_SC_RD  = 12'b000000000100,
        S_SC_EV  = 12'b000000001000,
        S_CP_RD  = 12'b000000010000,
        S_CP_EV  = 12'b000000100000,
        S_SH_RD  = 12'b000001000000,
        S_SH_WR  = 12'b000010000000,
        S_SPLIT0 = 12'b000100000000,
        S_SPLIT1 = 12'b001000000000,
        S_DONE   = 12'b010000000000,
        S_SPARE  = 12'b100000000000
    } t_state;

    t_state          r_state;
    logic [31:0]     r_region;
    logic [31:0]     r_slack;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_rd;
    logic [IW-1:0]   r_wr;
    logic [1:0]      r_op;
    logic [31:0]     r_size;
    logic [31:0]     r_target;
    logic            r_found;
    logic            r_retried;
    logic [IW-1:0]   r_best_idx;
    logic [AW-1:0]   r_best_len;
    logic [AW-1:0]   r_best_off;
    logic            r_prev_free;
    logic            r_have;
    logic            r_merge;
    logic            r_all;
    logic            r_tgt_en;
    logic [IW-1:0]   r_tgt_idx;
    logic [AW-1:0]   r_pend_off;
    logic [AW-1:0]   r_pend_len;
    logic            r_pend_free;
    logic [1:0]      r_res_status;
    logic [31:0]     r_res_addr;
    logic            r_out_valid;
    t_rsp            r_out;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;
    logic [IW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;

    logic [AW-1:0]   q_off;
    logic [AW-1:0]   q_len;
    logic            q_free;
    logic            e_free;
    logic [IW-1:0]   cur_idx;
    logic [XW-1:0]   size_x;
    logic            fits;
    logic [AW-1:0]   left_len;
    logic            whole;
    logic            cfg_wr;

    bfsa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign q_off   = mem_rdata[AW-1:0];
    assign q_len   = mem_rdata[2*AW-1:AW];
    assign q_free  = mem_rdata[EW-1];
    assign cur_idx = r_rd[IW-1:0];
    assign e_free  = q_free | (r_tgt_en && cur_idx == r_tgt_idx);
    assign size_x  = XW'(r_size);
    assign fits    = q_free && (size_x <= XW'(q_len));
    assign left_len = r_best_len - AW'(r_size);
    assign whole   = (size_x == XW'(r_best_len)) || (XW'(left_len) < XW'(r_slack));

    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_MIN_SLACK) ? r_slack : r_region;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    always_comb begin
        mem_raddr = cur_idx;
        if (r_state == S_SH_RD) begin
            mem_raddr = IW'(r_rd - CW'(1));
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = {1'b1, AW'(r_region), {AW{1'b0}}};
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                mem_we = i_in_valid && i_in_req.operation == OP_REINIT;
            end
            S_SC_RD: begin
                if (r_rd == r_count && r_op == OP_ALLOC && r_found && whole) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_best_idx;
                    mem_wdata = {1'b0, r_best_len, r_best_off};
                end
            end
            S_CP_RD: begin
                if (r_rd == r_count) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr;
                    mem_wdata = {r_pend_free, r_pend_len, r_pend_off};
                end
            end
            S_CP_EV: begin
                if (r_have && !(r_pend_free && e_free && (r_all || r_merge))) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr;
                    mem_wdata = {r_pend_free, r_pend_len, r_pend_off};
                end
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = mem_rdata;
            end
            S_SPLIT0: begin
                mem_we    = 1'b1;
                mem_waddr = r_best_idx;
                mem_wdata = {1'b1, left_len, r_best_off};
            end
            S_SPLIT1: begin
                mem_we    = 1'b1;
                mem_waddr = r_best_idx + IW'(1);
                mem_wdata = {1'b0, AW'(r_size), r_best_off + left_len};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region    <= REGION_SIZE_RST;
            r_slack     <= MIN_SLACK_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_REGION_SIZE) begin
                r_region <= pwdata;
            end else begin
                r_slack  <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_retried   <= 1'b0;
            r_have      <= 1'b0;
            r_merge     <= 1'b0;
            r_all       <= 1'b0;
            r_tgt_en    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_count <= CW'(1);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op         <= i_in_req.operation;
                        r_size       <= i_in_req.request_size;
                        r_target     <= i_in_req.target_address;
                        r_rd         <= '0;
                        r_found      <= 1'b0;
                        r_retried    <= 1'b0;
                        r_prev_free  <= 1'b0;
                        r_res_status <= ST_OK;
                        r_res_addr   <= '0;
                        case (i_in_req.operation)
                            OP_ALLOC, OP_FREE: begin
                                r_state <= S_SC_RD;
                            end
                            OP_REINIT: begin
                                r_count <= CW'(1);
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SC_RD: begin
                    if (r_rd != r_count) begin
                        r_state <= S_SC_EV;
                    end else if (r_op == OP_FREE) begin
                        r_res_status <= ST_NOT_FND;
                        r_state      <= S_DONE;
                    end else if (r_found) begin
                        if (whole) begin
                            r_res_addr <= 32'(r_best_off);
                            r_state    <= S_DONE;
                        end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                            r_res_status <= ST_TAB_FULL;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_SH_RD;
                        end
                    end else if (!r_retried) begin
                        r_retried <= 1'b1;
                        r_rd      <= '0;
                        r_wr      <= '0;
                        r_have    <= 1'b0;
                        r_merge   <= 1'b1;
                        r_all     <= 1'b1;
                        r_tgt_en  <= 1'b0;
                        r_state   <= S_CP_RD;
                    end else begin
                        r_res_status <= ST_NO_MEM;
                        r_state      <= S_DONE;
                    end
                end
                S_SC_EV: begin
                    r_rd        <= r_rd + CW'(1);
                    r_prev_free <= q_free;
                    r_state     <= S_SC_RD;
                    if (r_op == OP_ALLOC) begin
                        if (fits && (!r_found || r_best_len > q_len)) begin
                            r_found    <= 1'b1;
                            r_best_idx <= cur_idx;
                            r_best_len <= q_len;
                            r_best_off <= q_off;
                        end
                    end else if (XW'(q_off) == XW'(r_target)) begin
                        r_tgt_en  <= 1'b1;
                        r_tgt_idx <= cur_idx;
                        r_have    <= 1'b0;
                        r_merge   <= 1'b1;
                        r_all     <= 1'b0;
                        r_state   <= S_CP_RD;
                        if (cur_idx != '0 && r_prev_free) begin
                            r_rd <= r_rd - CW'(1);
                            r_wr <= cur_idx - IW'(1);
                        end else begin
                            r_rd <= r_rd;
                            r_wr <= cur_idx;
                        end
                    end
                end
                S_CP_RD: begin
                    if (r_rd != r_count) begin
                        r_state <= S_CP_EV;
                    end else begin
                        r_count  <= CW'(r_wr) + CW'(1);
                        r_tgt_en <= 1'b0;
                        if (r_op == OP_ALLOC) begin
                            r_rd    <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SC_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CP_EV: begin
                    r_rd    <= r_rd + CW'(1);
                    r_state <= S_CP_RD;
                    if (!r_have) begin
                        r_have      <= 1'b1;
                        r_pend_off  <= q_off;
                        r_pend_len  <= q_len;
                        r_pend_free <= e_free;
                    end else if (r_pend_free && e_free && (r_all || r_merge)) begin
                        r_pend_len <= r_pend_len + q_len;
                    end else begin
                        r_wr        <= r_wr + IW'(1);
                        r_merge     <= 1'b0;
                        r_pend_off  <= q_off;
                        r_pend_len  <= q_len;
                        r_pend_free <= e_free;
                    end
                end
                S_SH_RD: begin
                    if (r_rd > CW'(r_best_idx) + CW'(1)) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_state <= S_SPLIT0;
                    end
                end
                S_SH_WR: begin
                    r_rd    <= r_rd - CW'(1);
                    r_state <= S_SH_RD;
                end
                S_SPLIT0: begin
                    r_state <= S_SPLIT1;
                end
                S_SPLIT1: begin
                    r_count    <= r_count + CW'(1);
                    r_res_addr <= 32'(r_best_off + left_len);
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.status        <= r_res_status;
                        r_out.alloc_address <= r_res_addr;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
